@@ rtl/core/arcbb_pkg.sv @@
// shared widths, stage indexes, angle codes and helper functions for the arc bounding box
package arcbb_pkg;

    localparam int COORD_BITS       = 16;
    localparam int RADIUS_FRAC_BITS = 8;
    localparam int OUT_W            = 18;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int CR_W       = 2 * DIFF_W + 1;
    localparam int ROOT_W     = DIFF_W + RADIUS_FRAC_BITS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int VAL_W      = COORD_BITS + RADIUS_FRAC_BITS + 3;
    localparam int EXT_W      = (VAL_W > OUT_W) ? VAL_W : OUT_W;
    localparam int IN_DATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8;

    // pipeline stage indexes
    localparam int ST1  = 0;
    localparam int ST2  = 1;
    localparam int ST3  = 2;
    localparam int SQ0  = 3;
    localparam int FA   = SQ0 + ROOT_W;
    localparam int OS   = FA + 1;
    localparam int NSTG = OS + 1;

    localparam logic signed [VAL_W-1:0] FX_ONE   = VAL_W'(1) <<< RADIUS_FRAC_BITS;
    localparam logic signed [VAL_W-1:0] FRAC_ONES = FX_ONE - VAL_W'(1);

    // even codes are exact cardinal angles, odd codes the open quadrants
    localparam logic [2:0] ANG_RIGHT = 3'd0;
    localparam logic [2:0] ANG_Q1    = 3'd1;
    localparam logic [2:0] ANG_UP    = 3'd2;
    localparam logic [2:0] ANG_Q2    = 3'd3;
    localparam logic [2:0] ANG_LEFT  = 3'd4;
    localparam logic [2:0] ANG_Q3    = 3'd5;
    localparam logic [2:0] ANG_DOWN  = 3'd6;
    localparam logic [2:0] ANG_Q4    = 3'd7;

    // which box side gets widened
    localparam int HIT_XMAX = 0;
    localparam int HIT_YMIN = 1;
    localparam int HIT_XMIN = 2;
    localparam int HIT_YMAX = 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] xmin;
        logic signed [COORD_BITS-1:0] ymin;
        logic signed [COORD_BITS-1:0] xmax;
        logic signed [COORD_BITS-1:0] ymax;
        logic [3:0]                   hit;
    } pay_t;

    function automatic logic [2:0] angle_code(input logic signed [DIFF_W-1:0] dx,
                                              input logic signed [DIFF_W-1:0] dy);
        logic [2:0] code;
        if (dy == '0)
            code = dx[DIFF_W-1] ? ANG_LEFT : ANG_RIGHT;
        else if (dx == '0)
            code = dy[DIFF_W-1] ? ANG_DOWN : ANG_UP;
        else if (!dx[DIFF_W-1])
            code = dy[DIFF_W-1] ? ANG_Q4 : ANG_Q1;
        else
            code = dy[DIFF_W-1] ? ANG_Q3 : ANG_Q2;
        return code;
    endfunction

    function automatic logic swept(input logic ccw, input logic a_gt_b,
                                   input logic [2:0] ca, input logic [2:0] cb,
                                   input logic [2:0] c);
        logic r;
        if (ccw)
            r = a_gt_b ? (ca <= c || c <= cb) : (ca <= c && c <= cb);
        else
            r = a_gt_b ? (cb <= c && c <= ca) : (c <= ca || cb <= c);
        return r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] max3(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c);
        logic signed [COORD_BITS-1:0] m;
        m = (a > b) ? a : b;
        if (c > m)
            m = c;
        return m;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] min3(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c);
        logic signed [COORD_BITS-1:0] m;
        m = (a < b) ? a : b;
        if (c < m)
            m = c;
        return m;
    endfunction

    // drop the fraction bits, rounding toward zero
    function automatic logic signed [VAL_W-1:0] trunc_fx(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] bias;
        bias = v[VAL_W-1] ? FRAC_ONES : '0;
        return (v + bias) >>> RADIUS_FRAC_BITS;
    endfunction

    // wrap or sign extend to the output width
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [VAL_W-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[OUT_W-1:0];
    endfunction

endpackage

@@ rtl/core/arc_bounding_box_unit.sv @@
// arc bounding box: integer box of a circular arc, fully pipelined
//
// s_tdata carries one arc per beat (center, start, middle, end point),
// s_tuser the sweep sense; m_tdata returns the four box edges, one beat
// out for every beat in, in order.
// pipeline: three stages for differences, products and sweep tests,
// one stage per radius bit in the square root, then two stages for
// the widened edges and the output.
// throughput: one arc per cycle while m_tready is high; the square root
// is one compare and subtract per stage, so nothing in the pipe loops.
// every stage holds a valid bit; an empty stage always loads, so bubbles
// close up while m_tready is low and s_tready stays high until every
// stage holds a beat.
// reset clears all valid bits; the pipe is empty and ready right after.
module arc_bounding_box_unit
    import arcbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // center_x, center_y, start_x, start_y, mid_x, mid_y, end_x, end_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // direction
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // box_xmin, box_ymin, box_xmax, box_ymax
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int C = COORD_BITS;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   rdy;

    always_comb
    begin
        rdy[NSTG] = m_tready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i + 1];
        end
        for (int i = 0; i < NSTG; i++)
        begin
            if (!rdy[i])
                vld_next[i] = vld_reg[i];
            else if (i == 0)
                vld_next[i] = s_tvalid;
            else
                vld_next[i] = vld_reg[i - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = rdy[ST1];
    assign m_tvalid = vld_reg[OS];

    // stage 1: offsets from the center, y flipped
    logic signed [C-1:0] in_cx, in_cy, in_sx, in_sy, in_mx, in_my, in_ex, in_ey;
    assign in_cx = $signed(s_tdata[0*C +: C]);
    assign in_cy = $signed(s_tdata[1*C +: C]);
    assign in_sx = $signed(s_tdata[2*C +: C]);
    assign in_sy = $signed(s_tdata[3*C +: C]);
    assign in_mx = $signed(s_tdata[4*C +: C]);
    assign in_my = $signed(s_tdata[5*C +: C]);
    assign in_ex = $signed(s_tdata[6*C +: C]);
    assign in_ey = $signed(s_tdata[7*C +: C]);

    logic signed [DIFF_W-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg;
    logic signed [C-1:0]      cx1_reg, cy1_reg, sx1_reg, sy1_reg;
    logic signed [C-1:0]      mx1_reg, my1_reg, ex1_reg, ey1_reg;
    logic                     ccw1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST1])
        begin
            adx_reg  <= DIFF_W'(in_sx) - DIFF_W'(in_cx);
            ady_reg  <= DIFF_W'(in_cy) - DIFF_W'(in_sy);
            bdx_reg  <= DIFF_W'(in_ex) - DIFF_W'(in_cx);
            bdy_reg  <= DIFF_W'(in_cy) - DIFF_W'(in_ey);
            cx1_reg  <= in_cx;
            cy1_reg  <= in_cy;
            sx1_reg  <= in_sx;
            sy1_reg  <= in_sy;
            mx1_reg  <= in_mx;
            my1_reg  <= in_my;
            ex1_reg  <= in_ex;
            ey1_reg  <= in_ey;
            ccw1_reg <= s_tuser[0];
        end
    end

    // stage 2: squares, cross terms, angle codes, point bounds
    logic [DIFF_W-1:0]          mag_ax, mag_ay;
    logic [SQ_W-1:0]            sqa_reg, sqb_reg;
    logic signed [SQ_W-1:0]     p1_reg, p2_reg;
    logic [2:0]                 ca2_reg, cb2_reg;
    logic                       ccw2_reg;
    pay_t                       pay2_reg;

    assign mag_ax = adx_reg[DIFF_W-1] ? DIFF_W'(-adx_reg) : DIFF_W'(adx_reg);
    assign mag_ay = ady_reg[DIFF_W-1] ? DIFF_W'(-ady_reg) : DIFF_W'(ady_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[ST2])
        begin
            sqa_reg       <= SQ_W'(mag_ax) * SQ_W'(mag_ax);
            sqb_reg       <= SQ_W'(mag_ay) * SQ_W'(mag_ay);
            p1_reg        <= SQ_W'(bdx_reg) * SQ_W'(ady_reg);
            p2_reg        <= SQ_W'(bdy_reg) * SQ_W'(adx_reg);
            ca2_reg       <= angle_code(adx_reg, ady_reg);
            cb2_reg       <= angle_code(bdx_reg, bdy_reg);
            ccw2_reg      <= ccw1_reg;
            pay2_reg.cx   <= cx1_reg;
            pay2_reg.cy   <= cy1_reg;
            pay2_reg.xmin <= min3(sx1_reg, mx1_reg, ex1_reg);
            pay2_reg.xmax <= max3(sx1_reg, mx1_reg, ex1_reg);
            pay2_reg.ymin <= min3(sy1_reg, my1_reg, ey1_reg);
            pay2_reg.ymax <= max3(sy1_reg, my1_reg, ey1_reg);
            pay2_reg.hit  <= '0;
        end
    end

    // stage 3: radius squared and which sides the sweep crosses
    logic signed [CR_W-1:0] cross_prod;
    logic                   a_gt_b;
    logic [3:0]             hit3;
    logic [SQ_W-1:0]        rad3_reg;
    pay_t                   pay3_reg;
    pay_t                   pay3_next;

    assign cross_prod = CR_W'(p1_reg) - CR_W'(p2_reg);

    always_comb
    begin
        if (ca2_reg != cb2_reg)
            a_gt_b = ca2_reg > cb2_reg;
        else if (ca2_reg[0])
            a_gt_b = !cross_prod[CR_W-1] && (cross_prod != '0);
        else
            a_gt_b = 1'b0;
        hit3[HIT_XMAX] = swept(ccw2_reg, a_gt_b, ca2_reg, cb2_reg, ANG_RIGHT);
        hit3[HIT_YMIN] = swept(ccw2_reg, a_gt_b, ca2_reg, cb2_reg, ANG_UP);
        hit3[HIT_XMIN] = swept(ccw2_reg, a_gt_b, ca2_reg, cb2_reg, ANG_LEFT);
        hit3[HIT_YMAX] = swept(ccw2_reg, a_gt_b, ca2_reg, cb2_reg, ANG_DOWN);
        pay3_next      = pay2_reg;
        pay3_next.hit  = hit3;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST3])
        begin
            rad3_reg <= sqa_reg + sqb_reg;
            pay3_reg <= pay3_next;
        end
    end

    // square root, one result bit per stage; fraction digits see zero pairs
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W];
    logic [SQ_W-1:0]   sq_rad_reg  [ROOT_W];
    pay_t              sq_pay_reg  [ROOT_W];
    logic [REM_W-1:0]  sq_rem_next [ROOT_W];
    logic [ROOT_W-1:0] sq_root_next[ROOT_W];
    logic [SQ_W-1:0]   sq_rad_next [ROOT_W];
    pay_t              sq_pay_next [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sq
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   rad_in;
        pay_t              pay_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad3_reg;
            assign pay_in  = pay3_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rad_in  = sq_rad_reg[k-1];
            assign pay_in  = sq_pay_reg[k-1];
        end

        assign cur   = {rem_in, rad_in[SQ_W-1 -: 2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});
        assign take  = cur >= trial;

        assign sq_rem_next[k]  = take ? REM_W'(cur - trial) : REM_W'(cur);
        assign sq_root_next[k] = {root_in[ROOT_W-2:0], take};
        assign sq_rad_next[k]  = {rad_in[SQ_W-3:0], 2'b00};
        assign sq_pay_next[k]  = pay_in;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (rdy[SQ0 + k])
            begin
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_rad_reg[k]  <= sq_rad_next[k];
                sq_pay_reg[k]  <= sq_pay_next[k];
            end
        end
    end

    // widened edges: center +/- (radius + 1), still scaled
    pay_t                    sq_pay_last;
    logic signed [VAL_W-1:0] r_ext, cxs, cys;
    logic signed [VAL_W-1:0] fa_xmin_reg, fa_ymin_reg, fa_xmax_reg, fa_ymax_reg;
    pay_t                    fa_pay_reg;

    assign sq_pay_last = sq_pay_reg[ROOT_W-1];
    assign r_ext = $signed(VAL_W'(sq_root_reg[ROOT_W-1]));
    assign cxs   = VAL_W'(sq_pay_last.cx) <<< RADIUS_FRAC_BITS;
    assign cys   = VAL_W'(sq_pay_last.cy) <<< RADIUS_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (rdy[FA])
        begin
            fa_xmax_reg <= cxs + r_ext + FX_ONE;
            fa_xmin_reg <= cxs - r_ext - FX_ONE;
            fa_ymax_reg <= cys + r_ext + FX_ONE;
            fa_ymin_reg <= cys - r_ext - FX_ONE;
            fa_pay_reg  <= sq_pay_last;
        end
    end

    // output register
    logic signed [OUT_W-1:0] box_xmin_reg, box_ymin_reg, box_xmax_reg, box_ymax_reg;
    logic signed [OUT_W-1:0] box_xmin_next, box_ymin_next, box_xmax_next, box_ymax_next;

    always_comb
    begin
        box_xmin_next = fa_pay_reg.hit[HIT_XMIN] ? to_out(trunc_fx(fa_xmin_reg))
                                                 : to_out(VAL_W'(fa_pay_reg.xmin));
        box_ymin_next = fa_pay_reg.hit[HIT_YMIN] ? to_out(trunc_fx(fa_ymin_reg))
                                                 : to_out(VAL_W'(fa_pay_reg.ymin));
        box_xmax_next = fa_pay_reg.hit[HIT_XMAX] ? to_out(trunc_fx(fa_xmax_reg))
                                                 : to_out(VAL_W'(fa_pay_reg.xmax));
        box_ymax_next = fa_pay_reg.hit[HIT_YMAX] ? to_out(trunc_fx(fa_ymax_reg))
                                                 : to_out(VAL_W'(fa_pay_reg.ymax));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OS])
        begin
            box_xmin_reg <= box_xmin_next;
            box_ymin_reg <= box_ymin_next;
            box_xmax_reg <= box_xmax_next;
            box_ymax_reg <= box_ymax_next;
        end
    end

    assign m_tdata = OUT_DATA_W'({box_ymax_reg, box_xmax_reg, box_ymin_reg, box_xmin_reg});

    // an empty output stage means every stage can load
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("output stage empty but input not ready");

    a_taken_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("receiver ready but input not ready");

    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[ST1])
        else $error("accepted beat not held in first stage");

    // square root remainder never exceeds twice the root
    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FA - 1] |->
            (sq_rem_reg[ROOT_W-1] <= REM_W'({sq_root_reg[ROOT_W-1], 1'b0})))
        else $error("square root remainder out of range");

endmodule
